/* design/aes128_block_encrypt_core_macros.svh */
// Assertion macros for the AES-128 encryption core
`ifndef AES128_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AES_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define AES_ASSERT(label, clk, rst_n, prop, msg)
`define AES_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* design/aes_pkg.sv */
// Types, constants and round functions for the AES-128 encryption core
package aes_pkg;
    localparam int unsigned NumRounds = 10;
    localparam int unsigned NumStages = NumRounds + 1;

    typedef logic [127:0] t_block;
    typedef logic [7:0]   t_byte;

    typedef enum logic {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_idx;

    localparam t_byte SboxTab [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_byte RconTab [11] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    localparam t_byte GfPoly = 8'h1b;

    // byte k of the block sits in bits 127-8k .. 120-8k
    function automatic t_byte get_byte(t_block b, int unsigned k);
        return b[127 - 8*k -: 8];
    endfunction

    function automatic t_byte gmul2(t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
    endfunction

    // next round key from the previous one; rc is the round constant to apply
    function automatic t_block next_key(t_block k, t_byte rc);
        logic [31:0] w [4];
        logic [31:0] t;
        t_block      o;
        for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
        t = {SboxTab[w[3][23:16]] ^ rc, SboxTab[w[3][15:8]],
             SboxTab[w[3][7:0]], SboxTab[w[3][31:24]]};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        for (int i = 0; i < 4; i++) o[127 - 32*i -: 32] = w[i];
        return o;
    endfunction

    function automatic t_block sub_shift(t_block s);
        t_block o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127 - 8*(r + 4*c) -: 8] = SboxTab[get_byte(s, r + 4*((c + r) % 4))];
        return o;
    endfunction

    function automatic t_block mix_cols(t_block s);
        t_block o;
        t_byte  a0, a1, a2, a3, d0, d1, d2, d3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            d0 = gmul2(a0); d1 = gmul2(a1); d2 = gmul2(a2); d3 = gmul2(a3);
            o[127 - 32*c -: 8]  = d0 ^ d1 ^ a1 ^ a2 ^ a3;
            o[119 - 32*c -: 8]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
            o[111 - 32*c -: 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
            o[103 - 32*c -: 8]  = d0 ^ a0 ^ a1 ^ a2 ^ d3;
        end
        return o;
    endfunction
endpackage

/* design/aes_if.sv */
// Valid/ready channel interfaces for the AES-128 encryption core
interface aes_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    modport source (output valid, block_high, block_low, input ready);
    modport sink   (input valid, block_high, block_low, output ready);
endinterface

interface aes_ciph_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    modport source (output valid, cipher_high, cipher_low, input ready);
    modport sink   (input valid, cipher_high, cipher_low, output ready);
endinterface

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/aes128_block_encrypt_core.sv */
// Top level of the pipelined AES-128 block encryption core
// channel | direction | words
// s_blk   | in        | plaintext block_high/block_low
// m_ciph  | out       | ciphertext cipher_high/cipher_low
// s_cfg   | in        | key_high (index 0), key_low (index 1)
// Eleven register stages: initial key add, then one round per stage.
// One word accepted per cycle while the output is not stalled; key expanded alongside data.
// Synchronous active-low reset clears valid bits and resets the key to zero; stage data is not reset.
// A stall at the output freezes the whole pipeline; nothing is lost.
`include "aes128_block_encrypt_core_macros.svh"
module aes128_block_encrypt_core import aes_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    aes_blk_if.sink    s_blk,
    aes_ciph_if.source m_ciph,
    aes_cfg_if.sink    s_cfg
);
    logic [63:0] r_key_high, r_key_low;
    logic        r_v0;
    t_block      r_st0, r_k0;
    logic        en;
    logic   v  [NumStages];
    t_block st [NumStages];
    t_block ks [NumStages];

    assign en          = !v[NumStages-1] || m_ciph.ready;
    assign s_blk.ready = en;
    assign s_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (s_cfg.valid) begin
            unique case (t_cfg_idx'(s_cfg.index))
                CFG_KEY_HIGH: r_key_high <= s_cfg.data;
                CFG_KEY_LOW:  r_key_low  <= s_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en) r_v0 <= s_blk.valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st0 <= {s_blk.block_high, s_blk.block_low} ^ {r_key_high, r_key_low};
            r_k0  <= {r_key_high, r_key_low};
        end
    end

    assign v[0]  = r_v0;
    assign st[0] = r_st0;
    assign ks[0] = r_k0;

    for (genvar g = 1; g < NumStages; g++) begin : g_rnd
        aes_round #(.ROUND(g)) u_rnd (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(v[g-1]),
            .i_state(st[g-1]),
            .i_key  (ks[g-1]),
            .o_valid(v[g]),
            .o_state(st[g]),
            .o_key  (ks[g])
        );
    end

    assign m_ciph.valid       = v[NumStages-1];
    assign m_ciph.cipher_high = st[NumStages-1][127:64];
    assign m_ciph.cipher_low  = st[NumStages-1][63:0];

    `AES_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_ciph.valid && !m_ciph.ready, m_ciph.valid && $stable(m_ciph.cipher_high), "stalled output word changed")
    `AES_ASSERT(a_ready_stall, i_clk, i_rst_n, (m_ciph.valid && !m_ciph.ready) |-> !s_blk.ready, "input taken while pipeline frozen")
    `AES_ASSERT_NEXT(a_entry, i_clk, i_rst_n, s_blk.valid && s_blk.ready, r_v0, "accepted word not in first stage")
endmodule

/* design/aes_round.sv */
// One pipeline stage: one AES round on the state and one key-schedule step
module aes_round import aes_pkg::*; #(
    parameter int unsigned ROUND = 1
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_block i_state,
    input  t_block i_key,
    output logic   o_valid,
    output t_block o_state,
    output t_block o_key
);
    logic   r_valid;
    t_block r_state, r_key;
    t_block n_state, n_key, ss;

    always_comb begin
        n_key = next_key(i_key, RconTab[ROUND]);
        ss    = sub_shift(i_state);
        if (ROUND == NumRounds) n_state = ss ^ n_key;
        else                    n_state = mix_cols(ss) ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (i_en) r_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
endmodule
